// ===== src/oaht_pkg.sv =====
// package for the open addressing hash table
// types, codes and sizes shared by controller, datapath and top level
`timescale 1ns / 1ps

package oaht_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_BITS    = 4;
    localparam int KEY_BITS    = 31;
    localparam int SIZE_BITS   = 5;
    localparam int CNT_BITS    = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_FULL    = 2'd1;
    localparam logic [1:0] TAG_DELETED = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_PROBE_MODE = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch item, start reduction
        logic hash_step; // one reduction step
        logic probe_init;
        logic probe_step;
        logic write_full;
        logic write_del;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic tag_empty;
        logic tag_full;
        logic key_match;
        logic last_probe;
    } t_status;

endpackage

// ===== src/open_addressing_hash_table.sv =====
// top level of the open addressing hash table: apb registers, controller, datapath
// depends on oaht_pkg, oaht_ctrl, oaht_datapath
`timescale 1ns / 1ps
// usage
//   raise i_start with i_kind and i_key while o_busy is low; the transfer is taken then
//   o_done pulses for one cycle with o_status and o_slot; the receiver cannot stall
//   o_busy stays high from the transfer until the cycle after o_done
//   an item passes a reduction (one step per remainder bit of the 31-bit key,
//   then a finishing step that starts probing), then probing of up to
//   slot count slots, then a result state that shows o_done; a new transfer
//   is taken once o_busy is low again, so one item is in flight at a time
//   the probe loop reads one slot per cycle from the tag and key store
//   apb: register 0 slot count at 0x0, register 1 probe_mode at 0x4
//   write registers only while o_busy is low
//   reset: all slots empty, slot count 10, linear probing

module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_kind,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_busy,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [3:0]          o_slot,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SIZE_BITS-1:0] r_size;
    logic r_mode;
    t_cmd w_cmd;
    t_status w_stat;
    logic [IDX_BITS-1:0] w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_BITS'(10);
            r_mode <= 1'b0;
        end else if (w_wr) begin
            case ({1'b0, paddr[2]})
                REG_TABLE_SIZE: r_size <= pwdata[SIZE_BITS-1:0];
                REG_PROBE_MODE: r_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case ({1'b0, paddr[2]})
            REG_TABLE_SIZE: prdata = 32'(r_size);
            REG_PROBE_MODE: prdata = 32'(r_mode);
            default: prdata = '0;
        endcase
    end

    oaht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_kind(i_kind),
        .i_stat(w_stat), .i_idx(w_idx), .o_cmd(w_cmd), .o_busy(o_busy),
        .o_done(o_done), .o_status(o_status), .o_slot(o_slot)
    );

    oaht_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_key(i_key),
        .i_size(r_size), .i_mode(r_mode), .o_stat(w_stat), .o_idx(w_idx)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done without busy");
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_slot == '0) else $error("slot not zero");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.write_full && w_cmd.write_del)) else $error("double write");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");

endmodule

// ===== src/oaht_datapath.sv =====
// datapath: key modulo reduction, probe index generation, slot tag and key store
// depends on oaht_pkg
`timescale 1ns / 1ps

module oaht_datapath
    import oaht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [KEY_BITS-1:0]  i_key,
    input  logic [SIZE_BITS-1:0] i_size,
    input  logic                 i_mode,
    output t_status              o_stat,
    output logic [IDX_BITS-1:0]  o_idx
);

    logic [KEY_BITS-1:0]  r_rem, n_rem;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  r_dvs;
    logic [5:0]           r_sh, n_sh;
    logic [SIZE_BITS-1:0] r_size;
    logic                 r_mode;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic [CNT_BITS-1:0]  r_i;
    logic [SIZE_BITS-1:0] r_odd;
    logic [1:0]           r_tag [TABLE_DEPTH];
    logic [KEY_BITS-1:0]  r_skey [TABLE_DEPTH];
    logic [SIZE_BITS-1:0] w_use;
    logic [KEY_BITS-1:0]  w_trial;
    logic [SIZE_BITS:0]   w_sum;
    logic [SIZE_BITS-1:0] w_step;
    logic [SIZE_BITS-1:0] w_odd;

    always_comb begin
        w_use = i_size;
        if (i_size == '0) w_use = SIZE_BITS'(1);
        if (i_size > SIZE_BITS'(TABLE_DEPTH)) w_use = SIZE_BITS'(TABLE_DEPTH);
    end

    // restoring reduction, one shift position a cycle, from bit 30 down to bit 0
    always_comb begin
        w_trial = KEY_BITS'({r_dvs} << r_sh);
        n_rem = r_rem;
        n_sh = r_sh;
        if (i_cmd.hash_step) begin
            if (r_rem >= w_trial && (w_trial >> r_sh) == r_dvs) n_rem = r_rem - w_trial;
            n_sh = r_sh - 6'd1;
        end
    end

    // next probe: linear +1, quadratic adds odd numbers 1,3,5..
    always_comb begin
        w_step = r_mode ? r_odd : SIZE_BITS'(1);
        w_sum = {1'b0, SIZE_BITS'(r_idx)} + {1'b0, w_step};
        if (w_sum >= {1'b0, r_size}) w_sum = w_sum - {1'b0, r_size};
        if (w_sum >= {1'b0, r_size}) w_sum = w_sum - {1'b0, r_size};
        n_idx = w_sum[IDX_BITS-1:0];
    end

    // odd step kept modulo size
    always_comb begin
        w_odd = r_odd + SIZE_BITS'(2);
        if (w_odd >= r_size) w_odd = w_odd - r_size;
        if (w_odd >= r_size) w_odd = w_odd - r_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh <= 6'h3F;
        end else if (i_cmd.load) begin
            r_rem  <= i_key;
            r_key  <= i_key;
            r_dvs  <= KEY_BITS'(w_use);
            r_size <= w_use;
            r_mode <= i_mode;
            r_sh   <= 6'd30;
        end else begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
        if (i_cmd.probe_init) begin
            r_idx  <= r_rem[IDX_BITS-1:0];
            r_i    <= '0;
            r_odd  <= SIZE_BITS'(1);
        end else if (i_cmd.probe_step) begin
            r_idx <= n_idx;
            r_i   <= r_i + CNT_BITS'(1);
            r_odd <= w_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) r_tag[k] <= TAG_EMPTY;
        end else if (i_cmd.write_full) begin
            r_tag[r_idx] <= TAG_FULL;
        end else if (i_cmd.write_del) begin
            r_tag[r_idx] <= TAG_DELETED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_full) r_skey[r_idx] <= r_key;
    end

    // shift counter wraps past bit 0 when the reduction is finished
    assign o_stat.hash_done  = r_sh == 6'h3F;
    assign o_stat.tag_empty  = r_tag[r_idx] == TAG_EMPTY;
    assign o_stat.tag_full   = r_tag[r_idx] == TAG_FULL;
    assign o_stat.key_match  = r_skey[r_idx] == r_key;
    assign o_stat.last_probe = r_i == CNT_BITS'(r_size - SIZE_BITS'(1));
    assign o_idx = r_idx;

endmodule

// ===== src/oaht_ctrl.sv =====
// controller state machine sequencing reduction, probing and the result strobe
// depends on oaht_pkg
`timescale 1ns / 1ps

module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_kind,
    input  t_status             i_stat,
    input  logic [IDX_BITS-1:0] i_idx,
    output t_cmd                o_cmd,
    output logic                o_busy,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [IDX_BITS-1:0] o_slot
);

    t_state r_state, n_state;
    logic [1:0] r_kind;
    logic [1:0] r_st, n_st;
    logic [IDX_BITS-1:0] r_slot, n_slot;
    logic w_hit, w_stop;

    always_comb begin
        w_hit = 1'b0;
        w_stop = 1'b0;
        n_st = ST_NOT_FOUND;
        n_slot = '0;
        case (r_kind)
            KIND_INSERT: begin
                w_hit = !i_stat.tag_full;
                n_st = w_hit ? ST_OK : ST_FULL;
                w_stop = w_hit || i_stat.last_probe;
            end
            KIND_SEARCH, KIND_DELETE: begin
                w_hit = i_stat.tag_full && i_stat.key_match;
                n_st = w_hit ? ST_OK : ST_NOT_FOUND;
                w_stop = w_hit || i_stat.tag_empty || i_stat.last_probe;
            end
            default: w_stop = 1'b1;
        endcase
        if (w_hit) n_slot = i_idx;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_HASH;
            S_HASH:  if (i_stat.hash_done) n_state = S_PROBE;
            S_PROBE: if (w_stop) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load = i_start;
            S_HASH: begin
                o_cmd.hash_step = !i_stat.hash_done;
                o_cmd.probe_init = i_stat.hash_done;
            end
            S_PROBE: begin
                o_cmd.probe_step = !w_stop;
                o_cmd.write_full = w_hit && r_kind == KIND_INSERT;
                o_cmd.write_del  = w_hit && r_kind == KIND_DELETE;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == S_IDLE && i_start) r_kind <= i_kind;
        if (r_state == S_PROBE && w_stop) begin
            r_st <= n_st;
            r_slot <= n_slot;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;
    assign o_status = r_st;
    assign o_slot = r_slot;

endmodule
